/* rtl/char_list_compacting_store_core_assert.svh */
// Assertion macros shared by the store core
`ifndef CHAR_LIST_COMPACTING_STORE_CORE_ASSERT_SVH
`define CHAR_LIST_COMPACTING_STORE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CLCS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("store core assertion failed");

// Next-cycle implication, checked out of reset
`define CLCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("store core assertion failed");

`endif

/* rtl/clcs_pkg.sv */
// Package: item types, operation and status codes, default capacity
package clcs_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_DEL_AT  = 3'd1;
  localparam logic [2:0] OP_DEL_ALL = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_value;
    logic [5:0] position;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [6:0] fill_count;
    logic [1:0] status;
  } out_item_t;

endpackage

/* rtl/clcs_if.sv */
// Channel interfaces: operation input and result output
interface clcs_in_if import clcs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface clcs_out_if import clcs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/clcs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data
module clcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/char_list_compacting_store_core.sv */
// Ordered byte list with append, delete-at, delete-all-matching, overwrite and read
//
// Channels: in_i takes one operation item (opcode, char_value, position);
// out_o gives one result item per operation (read_char, fill_count, status).
// Both use valid/ready; an item moves on a clock edge with both high.
// The entries live in one RAM with one write and one registered read port.
// Path from acceptance to result valid:
//   append, overwrite, rejected or unused operations: S_DONE, output register
//   read at a valid position: S_RDWAIT (registered RAM read), S_DONE, output register
//   delete at position p: S_SCAN over entries p to count - 1, S_DONE, output register
//   delete all matching: S_SCAN over all entries, S_DONE, output register
// Deletes stream the list through the RAM, one entry read and at most one
// written per cycle. One operation is in flight at a time; the next item
// is taken the cycle after the result enters the output register.
// The output register holds a result while the receiver stalls; a new item
// can be accepted and worked on meanwhile, and its result waits until the
// register is taken.
// Reset clears the fill count and empties the output; entries are not
// cleared and data at positions at or above the count is never used.
`include "char_list_compacting_store_core_assert.svh"

module char_list_compacting_store_core import clcs_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clcs_in_if.sink      in_i,
  clcs_out_if.source   out_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PW = (CW > 6) ? CW : 6;
  localparam int unsigned XW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CapV = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          vld_q, vld_d;
  logic [2:0]    op_q, op_d;
  logic [7:0]    val_q, val_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [7:0]    res_char_q, res_char_d;
  logic [1:0]    res_stat_q, res_stat_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q, out_item_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          accept;
  logic [PW-1:0] pos_w;
  logic [CW-1:0] pos_c;
  logic          pos_ok;
  logic          issue;
  logic          keep;
  logic [XW-1:0] fill_w;

  clcs_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and position check
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign pos_w      = PW'(in_i.payload.position);
  assign pos_c      = pos_w[CW-1:0];
  assign pos_ok     = pos_w < PW'(count_q);
  assign issue      = rd_q < count_q;
  assign keep       = (op_q == OP_DEL_ALL) ? (ram_rdata != val_q) : (idx_q != pos_q);
  assign fill_w     = XW'(count_q);

  // Sequencer: decode, compaction scan, read wait, result hand-off
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    idx_d       = idx_q;
    vld_d       = vld_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    res_char_d  = res_char_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_item_d  = out_item_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_wdata   = in_i.payload.char_value;
    ram_raddr   = pos_c[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d       = in_i.payload.opcode;
          val_d      = in_i.payload.char_value;
          pos_d      = pos_c;
          res_char_d = 8'd0;
          res_stat_d = ST_OK;
          state_d    = S_DONE;
          case (in_i.payload.opcode)
            OP_APPEND: begin
              if (count_q < CapV) begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                res_stat_d = ST_FULL;
              end
            end
            OP_DEL_AT: begin
              if (pos_ok) begin
                rd_d    = pos_c;
                wr_d    = pos_c;
                vld_d   = 1'b0;
                state_d = S_SCAN;
              end else begin
                res_stat_d = ST_BADPOS;
              end
            end
            OP_DEL_ALL: begin
              rd_d    = '0;
              wr_d    = '0;
              vld_d   = 1'b0;
              state_d = S_SCAN;
            end
            OP_WRITE: begin
              if (pos_ok) begin
                ram_we    = 1'b1;
                ram_waddr = pos_c[AW-1:0];
              end else begin
                res_stat_d = ST_BADPOS;
              end
            end
            OP_READ: begin
              if (pos_ok) begin
                state_d = S_RDWAIT;
              end else begin
                res_stat_d = ST_BADPOS;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read, write back the entry returned last cycle if kept
        ram_raddr = rd_q[AW-1:0];
        vld_d     = issue;
        idx_d     = rd_q;
        if (issue) begin
          rd_d = rd_q + 1'b1;
        end
        if (vld_q && keep) begin
          ram_we    = 1'b1;
          ram_waddr = wr_q[AW-1:0];
          ram_wdata = ram_rdata;
          wr_d      = wr_q + 1'b1;
        end
        if (!vld_q && !issue) begin
          count_d = wr_q;
          state_d = S_DONE;
        end
      end

      S_RDWAIT: begin
        res_char_d = ram_rdata;
        state_d    = S_DONE;
      end

      S_DONE: begin
        // Move the result into the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d           = 1'b1;
          out_item_d.read_char  = res_char_q;
          out_item_d.fill_count = fill_w[6:0];
          out_item_d.status     = res_stat_q;
          state_d               = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_q       <= rd_d;
    wr_q       <= wr_d;
    idx_q      <= idx_d;
    op_q       <= op_d;
    val_q      <= val_d;
    pos_q      <= pos_d;
    res_char_q <= res_char_d;
    res_stat_q <= res_stat_d;
    out_item_q <= out_item_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  // Checks
  `CLCS_ASSERT_IMPL(a_count_cap, 1'b1, count_q <= CapV)
  `CLCS_ASSERT_IMPL(a_scan_no_overlap, state_q == S_SCAN && ram_we, wr_q < rd_q)
  `CLCS_ASSERT_NEXT(a_out_from_done, !out_valid_q && state_q != S_DONE, !out_valid_q)

endmodule

/* tb/tb_top.sv */
// Testbench for the compacting byte list core: directed table, then random operations
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clcs_pkg::*;

  localparam int unsigned LIST_CAP      = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS  = 1900;
  localparam int          WATCHDOG_MAX  = 2000;
  localparam int          TAIL_CYCLES   = 100;
  localparam int          DIR_ROWS      = 25;

  // Opcodes that the block leaves unused
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_MATCH} mix_mode_e;

  typedef struct packed {
    in_item_t  op;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  // Directed rows; typed expectations where they are obvious, the list model elsewhere
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{OP_READ,     8'h00, 6'd0},  1'b1, '{8'h00, 7'd0, ST_BADPOS}},
    '{'{OP_DEL_AT,   8'h00, 6'd0},  1'b1, '{8'h00, 7'd0, ST_BADPOS}},
    '{'{OP_WRITE,    8'h55, 6'd0},  1'b1, '{8'h00, 7'd0, ST_BADPOS}},
    '{'{OP_DEL_ALL,  8'h41, 6'd0},  1'b1, '{8'h00, 7'd0, ST_OK}},
    '{'{OP_SPARE_LO, 8'h00, 6'd0},  1'b1, '{8'h00, 7'd0, ST_OK}},
    '{'{OP_SPARE_HI, 8'hFF, 6'd63}, 1'b1, '{8'h00, 7'd0, ST_OK}},
    '{'{OP_APPEND,   8'h00, 6'd0},  1'b1, '{8'h00, 7'd1, ST_OK}},
    '{'{OP_APPEND,   8'hFF, 6'd63}, 1'b1, '{8'h00, 7'd2, ST_OK}},
    '{'{OP_APPEND,   8'h41, 6'd0},  1'b1, '{8'h00, 7'd3, ST_OK}},
    '{'{OP_APPEND,   8'hFF, 6'd0},  1'b1, '{8'h00, 7'd4, ST_OK}},
    '{'{OP_READ,     8'hFF, 6'd0},  1'b1, '{8'h00, 7'd4, ST_OK}},
    '{'{OP_READ,     8'h00, 6'd1},  1'b1, '{8'hFF, 7'd4, ST_OK}},
    '{'{OP_READ,     8'h00, 6'd4},  1'b1, '{8'h00, 7'd4, ST_BADPOS}},
    '{'{OP_READ,     8'h00, 6'd63}, 1'b1, '{8'h00, 7'd4, ST_BADPOS}},
    '{'{OP_WRITE,    8'h7E, 6'd3},  1'b0, '0},
    '{'{OP_READ,     8'h00, 6'd3},  1'b0, '0},
    '{'{OP_WRITE,    8'h11, 6'd4},  1'b1, '{8'h00, 7'd4, ST_BADPOS}},
    '{'{OP_DEL_AT,   8'h00, 6'd63}, 1'b1, '{8'h00, 7'd4, ST_BADPOS}},
    '{'{OP_DEL_ALL,  8'hFF, 6'd0},  1'b1, '{8'h00, 7'd3, ST_OK}},
    '{'{OP_READ,     8'h00, 6'd1},  1'b1, '{8'h41, 7'd3, ST_OK}},
    '{'{OP_DEL_AT,   8'h00, 6'd0},  1'b1, '{8'h00, 7'd2, ST_OK}},
    '{'{OP_READ,     8'h00, 6'd0},  1'b0, '0},
    '{'{OP_DEL_AT,   8'h00, 6'd1},  1'b1, '{8'h00, 7'd1, ST_OK}},
    '{'{OP_DEL_ALL,  8'h41, 6'd0},  1'b1, '{8'h00, 7'd0, ST_OK}},
    '{'{OP_DEL_ALL,  8'h41, 6'd0},  1'b1, '{8'h00, 7'd0, ST_OK}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  clcs_in_if  op_ch ();
  clcs_out_if res_ch ();

  char_list_compacting_store_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  // List model state
  logic [7:0]  list_mem [LIST_CAP];
  int unsigned list_len;

  out_item_t   pending_res_q [$];
  int          err_count = 0;
  int          idle_cycles = 0;
  int          sink_wait;
  bit          src_idle_on;
  bit          sink_idle_on;

  always #5 clk_i = ~clk_i;

  function automatic int draw_gap(bit on);
    return on ? int'($urandom_range(0, 3)) : 0;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Apply one operation to the list model and return its result
  function automatic out_item_t apply_list_op(in_item_t op);
    out_item_t   res;
    bit          pos_ok;
    int unsigned wr;
    res    = '0;
    pos_ok = (op.position < list_len);
    res.status = ST_OK;
    case (op.opcode)
      OP_APPEND: begin
        if (list_len < LIST_CAP) begin
          list_mem[list_len] = op.char_value;
          list_len++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_DEL_AT: begin
        if (pos_ok) begin
          for (int unsigned j = op.position; j + 1 < list_len; j++)
            list_mem[j] = list_mem[j + 1];
          list_len--;
        end else begin
          res.status = ST_BADPOS;
        end
      end
      OP_DEL_ALL: begin
        wr = 0;
        for (int unsigned rd = 0; rd < list_len; rd++) begin
          if (list_mem[rd] != op.char_value) begin
            list_mem[wr] = list_mem[rd];
            wr++;
          end
        end
        list_len = wr;
      end
      OP_WRITE: begin
        if (pos_ok) list_mem[op.position] = op.char_value;
        else res.status = ST_BADPOS;
      end
      OP_READ: begin
        if (pos_ok) res.read_char = list_mem[op.position];
        else res.status = ST_BADPOS;
      end
      default: ;
    endcase
    res.fill_count = 7'(list_len);
    return res;
  endfunction

  // Draw one random operation, weighted by the phase mode
  function automatic in_item_t pick_op(mix_mode_e mode);
    in_item_t op;
    int       r;
    int       w_app, w_del, w_all, w_wr;
    case (mode)
      MODE_FILL:  begin w_app = 80; w_del = 5;  w_all = 2;  w_wr = 6;  end
      MODE_DRAIN: begin w_app = 15; w_del = 45; w_all = 10; w_wr = 10; end
      MODE_MIX:   begin w_app = 35; w_del = 20; w_all = 5;  w_wr = 15; end
      default:    begin w_app = 45; w_del = 10; w_all = 15; w_wr = 10; end
    endcase
    // Narrow alphabet makes delete-all hit several entries
    if (mode == MODE_MATCH) op.char_value = 8'hA4 | 8'($urandom_range(0, 3));
    else op.char_value = 8'($urandom_range(0, 255));
    if (list_len > 0 && $urandom_range(0, 9) < 8)
      op.position = 6'($urandom_range(0, list_len - 1));
    else
      op.position = 6'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < w_app) begin
      op.opcode = OP_APPEND;
    end else if (r < w_app + w_del) begin
      op.opcode = OP_DEL_AT;
    end else if (r < w_app + w_del + w_all) begin
      op.opcode = OP_DEL_ALL;
      if (list_len > 0 && $urandom_range(0, 9) < 7)
        op.char_value = list_mem[$urandom_range(0, list_len - 1)];
    end else if (r < w_app + w_del + w_all + w_wr) begin
      op.opcode = OP_WRITE;
    end else if (r < 97) begin
      op.opcode = OP_READ;
    end else begin
      case ($urandom_range(0, 2))
        0:       op.opcode = OP_SPARE_LO;
        1:       op.opcode = OP_SPARE_MID;
        default: op.opcode = OP_SPARE_HI;
      endcase
    end
    return op;
  endfunction

  // Present one item, hold it until taken, then record its expected result
  task automatic send_op(input in_item_t op, input bit typed, input out_item_t typed_want);
    int        gap;
    out_item_t model_res;
    out_item_t exp_res;
    gap = draw_gap(src_idle_on);
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_ch.valid   <= 1'b1;
    op_ch.payload <= op;
    do @(posedge clk_i); while (!op_ch.ready);
    model_res = apply_list_op(op);
    exp_res   = typed ? typed_want : model_res;
    pending_res_q = {pending_res_q, exp_res};
  endtask

  // Compare one result against the oldest expectation
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_res_q.size() == 0) begin
      report_error($sformatf("result with nothing pending: char %0h count %0d status %0d",
                             got.read_char, got.fill_count, got.status));
      return;
    end
    want = pending_res_q.pop_front();
    if (got.read_char !== want.read_char)
      report_error($sformatf("read_char got %0h expected %0h", got.read_char, want.read_char));
    if (got.fill_count !== want.fill_count)
      report_error($sformatf("fill_count got %0d expected %0d", got.fill_count,
                             want.fill_count));
    if (got.status !== want.status)
      report_error($sformatf("status got %0d expected %0d", got.status, want.status));
  endtask

  // Result side: take results, stall at random between them
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    int gap;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      sink_wait    <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      check_result(res_ch.payload);
      gap = draw_gap(sink_idle_on);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        sink_wait    <= gap;
      end
    end else if (!res_ch.ready) begin
      if (sink_wait <= 1) begin
        res_ch.ready <= 1'b1;
        sink_wait    <= 0;
      end else begin
        sink_wait <= sink_wait - 1;
      end
    end
  end

  // Watchdog: end the run after too long without any item moving
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    mix_mode_e mode;
    int        sent;
    int        phase_len;
    bit        first_phase;
    list_len      = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    rst_ni        <= 1'b0;
    op_ch.valid   <= 1'b0;
    op_ch.payload <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_op(DIR_TABLE[i].op, DIR_TABLE[i].typed, DIR_TABLE[i].want);

    // Random phases; the first one fills the list up to and past full
    sent        = 0;
    first_phase = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      mode         = first_phase ? MODE_FILL : mix_mode_e'($urandom_range(0, 3));
      phase_len    = first_phase ? 160 : int'($urandom_range(40, 160));
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      first_phase  = 1'b0;
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        send_op(pick_op(mode), 1'b0, '0);
        sent++;
      end
    end
    op_ch.valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
